// File: sv/ipudp_pkg.sv
`default_nettype none
package ipudp_pkg;

    // Header field constants
    localparam logic [7:0]  IP_VER_IHL   = 8'h45;
    localparam logic [7:0]  IP_TTL       = 8'hff;
    localparam logic [7:0]  IP_PROTO_UDP = 8'h11;
    localparam logic [15:0] IP_HDR_LEN   = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN  = 16'd8;

    // Header word positions
    localparam logic [2:0] W_VER_LEN   = 3'd0;
    localparam logic [2:0] W_ID_FRAG   = 3'd1;
    localparam logic [2:0] W_TTL_CSUM  = 3'd2;
    localparam logic [2:0] W_SRC_IP    = 3'd3;
    localparam logic [2:0] W_DST_IP    = 3'd4;
    localparam logic [2:0] W_PORTS     = 3'd5;
    localparam logic [2:0] W_UDP_LCSUM = 3'd6;

    // Byte count codes
    localparam logic [1:0] BC_NONE = 2'd0;
    localparam logic [1:0] BC_ONE  = 2'd1;

    // Configuration register indexes
    localparam logic CFG_SOURCE_IP   = 1'b0;
    localparam logic CFG_SOURCE_PORT = 1'b1;

    // Datagram queue geometry
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);

    // One finished datagram, handed from front to back
    typedef struct packed {
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [15:0] payload_sum;
        logic [15:0] payload_bytes;
        logic        oversize;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM1,
        B_SUM2,
        B_FOLD,
        B_EMIT
    } t_back_state;

endpackage
`default_nettype wire

// File: sv/ipudp_front.sv
`default_nettype none
module ipudp_front
    import ipudp_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD_BYTES = 1472
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [31:0] i_dest_ip,
    input  wire logic [15:0] i_dest_port,
    input  wire logic [15:0] i_payload_word,
    input  wire logic [1:0]  i_byte_count,
    input  wire logic        i_last_word,
    output logic             o_push,
    output t_desc            o_desc
);

    logic        r_in_dg;
    logic [15:0] r_sum;
    logic [15:0] r_bytes;
    logic [31:0] r_dest_ip;
    logic [15:0] r_dest_port;
    logic        r_over;

    logic        first;
    logic [15:0] base_sum;
    logic [15:0] base_bytes;
    logic        base_over;
    logic [1:0]  cnt_eff;
    logic [15:0] word_eff;
    logic [16:0] grow;
    logic        add_en;
    logic [16:0] sum_raw;
    logic [15:0] n_sum;
    logic [15:0] n_bytes;
    logic        n_over;

    // Start of a datagram restarts sum, count and flag from zero
    always_comb begin
        first      = !r_in_dg;
        base_sum   = first ? 16'd0 : r_sum;
        base_bytes = first ? 16'd0 : r_bytes;
        base_over  = first ? 1'b0  : r_over;
    end

    // Byte count clean-up: three counts as two, one keeps the high byte only
    always_comb begin
        case (i_byte_count)
            BC_NONE: cnt_eff = 2'd0;
            BC_ONE:  cnt_eff = 2'd1;
            default: cnt_eff = 2'd2;
        endcase
        word_eff = (i_byte_count == BC_ONE) ? {i_payload_word[15:8], 8'h00}
                                            : i_payload_word;
    end

    // Length check and end-around-carry accumulate
    always_comb begin
        grow    = {1'b0, base_bytes} + {15'd0, cnt_eff};
        n_over  = base_over
                  || ((cnt_eff != 2'd0) && (grow > 17'(MAX_PAYLOAD_BYTES)));
        add_en  = (cnt_eff != 2'd0) && !n_over;
        sum_raw = {1'b0, base_sum} + {1'b0, word_eff};
        n_sum   = add_en ? (sum_raw[15:0] + {15'd0, sum_raw[16]}) : base_sum;
        n_bytes = add_en ? grow[15:0] : base_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_dg <= 1'b0;
        end else if (i_accept) begin
            r_in_dg <= !i_last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sum   <= n_sum;
            r_bytes <= n_bytes;
            r_over  <= n_over;
            if (first) begin
                r_dest_ip   <= i_dest_ip;
                r_dest_port <= i_dest_port;
            end
        end
    end

    // Hand the finished datagram to the queue on its last word
    always_comb begin
        o_push                = i_accept && i_last_word;
        o_desc.dest_ip        = first ? i_dest_ip : r_dest_ip;
        o_desc.dest_port      = first ? i_dest_port : r_dest_port;
        o_desc.payload_sum    = n_sum;
        o_desc.payload_bytes  = n_bytes;
        o_desc.oversize       = n_over;
    end

endmodule
`default_nettype wire

// File: sv/ipudp_queue.sv
`default_nettype none
module ipudp_queue
    import ipudp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_desc      i_desc,
    input  wire logic  i_pop,
    output t_desc      o_desc,
    output t_q_status  o_status
);

    t_desc              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;

    logic do_push;
    logic do_pop;

    always_comb begin
        o_status.full  = (r_count == (QPTR_W+1)'(Q_DEPTH));
        o_status.empty = (r_count == '0);
        do_push        = i_push && !o_status.full;
        do_pop         = i_pop && !o_status.empty;
        o_desc         = r_mem[r_rd_ptr];
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule
`default_nettype wire

// File: sv/ipudp_back.sv
`default_nettype none
module ipudp_back
    import ipudp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_source_ip,
    input  wire logic [15:0] i_source_port,
    input  t_desc            i_desc,
    input  t_q_status        i_q_status,
    output logic             o_pop,
    input  wire logic        i_stall,
    output logic             o_valid,
    output logic [31:0]      o_header_word,
    output logic [2:0]       o_word_index,
    output logic             o_final_word,
    output logic             o_dropped
);

    t_back_state r_state;
    t_back_state n_state;

    t_desc       r_d;
    logic [15:0] r_tot_len;
    logic [15:0] r_udp_len;
    logic [18:0] r_ip_a;
    logic [16:0] r_ip_b;
    logic [18:0] r_udp_a;
    logic [18:0] r_udp_b;
    logic [19:0] r_ip_s;
    logic [19:0] r_udp_s;
    logic [15:0] r_ip_csum;
    logic [15:0] r_udp_csum;
    logic [2:0]  r_idx;

    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_index;
    logic        r_out_final;
    logic        r_out_dropped;

    logic        out_load;
    logic        emit;
    logic        emit_last;
    logic [31:0] cur_word;
    logic [16:0] ip_f1;
    logic [16:0] udp_f1;

    assign out_load = !r_out_valid || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = i_desc.oversize ? B_EMIT : B_SUM1;
                end
            end
            B_SUM1: n_state = B_SUM2;
            B_SUM2: n_state = B_FOLD;
            B_FOLD: n_state = B_EMIT;
            B_EMIT: begin
                if (out_load && emit_last) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // State outputs and header word select
    always_comb begin
        o_pop     = (r_state == B_IDLE) && !i_q_status.empty;
        emit      = (r_state == B_EMIT) && out_load;
        emit_last = r_d.oversize || (r_idx == W_UDP_LCSUM);
        case (r_idx)
            W_VER_LEN:   cur_word = {IP_VER_IHL, 8'h00, r_tot_len};
            W_ID_FRAG:   cur_word = 32'd0;
            W_TTL_CSUM:  cur_word = {IP_TTL, IP_PROTO_UDP, r_ip_csum};
            W_SRC_IP:    cur_word = i_source_ip;
            W_DST_IP:    cur_word = r_d.dest_ip;
            W_PORTS:     cur_word = {i_source_port, r_d.dest_port};
            W_UDP_LCSUM: cur_word = {r_udp_len, r_udp_csum};
            default:     cur_word = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datagram capture and word counter
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_d       <= i_desc;
            r_tot_len <= i_desc.payload_bytes + IP_HDR_LEN + UDP_HDR_LEN;
            r_udp_len <= i_desc.payload_bytes + UDP_HDR_LEN;
            r_idx     <= W_VER_LEN;
        end else if (emit) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    // Checksum pipeline: partial sums, totals, fold and invert
    always_comb begin
        ip_f1  = {1'b0, r_ip_s[15:0]} + {13'd0, r_ip_s[19:16]};
        udp_f1 = {1'b0, r_udp_s[15:0]} + {13'd0, r_udp_s[19:16]};
    end

    always_ff @(posedge i_clk) begin
        r_ip_a  <= 19'({8'd0, IP_VER_IHL, 8'h00}) + 19'({IP_TTL, IP_PROTO_UDP})
                   + 19'(r_tot_len) + 19'(i_source_ip[31:16])
                   + 19'(i_source_ip[15:0]);
        r_ip_b  <= 17'(r_d.dest_ip[31:16]) + 17'(r_d.dest_ip[15:0]);
        r_udp_a <= 19'(i_source_ip[31:16]) + 19'(i_source_ip[15:0])
                   + 19'(r_d.dest_ip[31:16]) + 19'(r_d.dest_ip[15:0])
                   + 19'(IP_PROTO_UDP);
        r_udp_b <= 19'(r_udp_len) + 19'(r_udp_len) + 19'(i_source_port)
                   + 19'(r_d.dest_port) + 19'(r_d.payload_sum);
        r_ip_s     <= 20'(r_ip_a) + 20'(r_ip_b);
        r_udp_s    <= 20'(r_udp_a) + 20'(r_udp_b);
        r_ip_csum  <= ~(ip_f1[15:0] + {15'd0, ip_f1[16]});
        r_udp_csum <= ~(udp_f1[15:0] + {15'd0, udp_f1[16]});
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word    <= r_d.oversize ? 32'd0 : cur_word;
            r_out_index   <= r_d.oversize ? W_VER_LEN : r_idx;
            r_out_final   <= emit_last;
            r_out_dropped <= r_d.oversize;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_header_word = r_out_word;
    assign o_word_index  = r_out_index;
    assign o_final_word  = r_out_final;
    assign o_dropped     = r_out_dropped;

endmodule
`default_nettype wire

// File: sv/ipv4_udp_header_generator.sv
// Input: one payload word per cycle while o_stall is low; a datagram's last word enters
// a 4-deep queue. Output: once the back end is free, the first header word follows the
// last word's transfer, then one word per cycle while i_stall is low (7 words, or a
// single dropped result). The back end runs a fetch, 3 checksum stages and the words.
// Synchronous active-low reset clears the config registers, queue and control state.
`default_nettype none
module ipv4_udp_header_generator
    import ipudp_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD_BYTES = 1472
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Payload in
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_dest_ip,
    input  wire logic [15:0] i_dest_port,
    input  wire logic [15:0] i_payload_word,
    input  wire logic [1:0]  i_byte_count,
    input  wire logic        i_last_word,
    // Header out
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_header_word,
    output logic [2:0]       o_word_index,
    output logic             o_final_word,
    output logic             o_dropped
);

    logic [31:0] r_source_ip;
    logic [15:0] r_source_port;

    logic        in_accept;
    logic        push;
    logic        pop;
    t_desc       front_desc;
    t_desc       q_desc;
    t_q_status   q_status;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_ip   <= 32'd0;
            r_source_port <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SOURCE_IP:   r_source_ip   <= i_cfg_data;
                CFG_SOURCE_PORT: r_source_port <= i_cfg_data[15:0];
                default:         r_source_ip   <= r_source_ip;
            endcase
        end
    end

    // Input transfer when the queue has room
    assign o_stall   = q_status.full;
    assign in_accept = i_valid && !o_stall;

    ipudp_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_dest_ip      (i_dest_ip),
        .i_dest_port    (i_dest_port),
        .i_payload_word (i_payload_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .o_push         (push),
        .o_desc         (front_desc)
    );

    ipudp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (front_desc),
        .i_pop    (pop),
        .o_desc   (q_desc),
        .o_status (q_status)
    );

    ipudp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_source_ip   (r_source_ip),
        .i_source_port (r_source_port),
        .i_desc        (q_desc),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_header_word (o_header_word),
        .o_word_index  (o_word_index),
        .o_final_word  (o_final_word),
        .o_dropped     (o_dropped)
    );

endmodule
`default_nettype wire

// File: bench/ipv4_udp_header_generator_tb.sv
`timescale 1ns / 1ps
module ipv4_udp_header_generator_tb;
    import ipudp_pkg::*;

    localparam int MAX_BYTES = 1472;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_WORDS = 20;
    localparam logic [1:0] BC_TWO = 2'd2;
    localparam logic [1:0] BC_THREE = 2'd3;

    // One payload word as offered to the block
    typedef struct packed {
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [15:0] word;
        logic [1:0]  bcnt;
        logic        last;
    } t_payload_beat;

    // One header result
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
        logic        drop;
    } t_hdr_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_SOURCE_IP;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_dest_ip = '0;
    logic [15:0] i_dest_port = '0;
    logic [15:0] i_payload_word = '0;
    logic [1:0]  i_byte_count = BC_NONE;
    logic        i_last_word = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_header_word;
    logic [2:0]  o_word_index;
    logic        o_final_word;
    logic        o_dropped;

    ipv4_udp_header_generator #(
        .MAX_PAYLOAD_BYTES(MAX_BYTES)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_dest_ip(i_dest_ip),
        .i_dest_port(i_dest_port),
        .i_payload_word(i_payload_word),
        .i_byte_count(i_byte_count),
        .i_last_word(i_last_word),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_header_word(o_header_word),
        .o_word_index(o_word_index),
        .o_final_word(o_final_word),
        .o_dropped(o_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus and expectation stores
    t_payload_beat word_feed_q[$];
    t_payload_beat cur_beat;
    t_hdr_result   hdr_due_q[$];
    int  beats_left = 0;
    int  errors = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    bit  beat_taken = 1'b0;
    bit  jitter_on = 1'b1;

    // Shadow of the block's registers and datagram state
    logic [31:0] cfg_src_ip = '0;
    logic [15:0] cfg_src_port = '0;
    logic [15:0] acc_sum = '0;
    logic [15:0] acc_bytes = '0;
    logic [31:0] cur_dip = '0;
    logic [15:0] cur_dport = '0;
    bit          open_dgram = 1'b0;
    bit          too_long = 1'b0;

    function automatic logic [15:0] ones_fold(input logic [31:0] s);
        logic [31:0] t;
        t = 32'(s[15:0]) + 32'(s[31:16]);
        t = 32'(t[15:0]) + 32'(t[31:16]);
        return t[15:0];
    endfunction

    function automatic void push_header_word(input logic [31:0] w, input logic [2:0] idx,
                                             input logic fin, input logic drop);
        t_hdr_result r;
        r.word = w;
        r.idx = idx;
        r.fin = fin;
        r.drop = drop;
        hdr_due_q.push_back(r);
    endfunction

    // Fold one accepted payload word into the datagram; emit headers on the last word
    function automatic void advance_datagram(input t_payload_beat b);
        logic [1:0]  c;
        logic [15:0] w;
        logic [15:0] tot_len;
        logic [15:0] udp_len;
        logic [31:0] w0;
        logic [31:0] w2;
        logic [31:0] s;
        logic [15:0] udp_ck;
        if (!open_dgram) begin
            cur_dip = b.dest_ip;
            cur_dport = b.dest_port;
            acc_sum = '0;
            acc_bytes = '0;
            too_long = 1'b0;
            open_dgram = 1'b1;
        end
        c = (b.bcnt == BC_THREE) ? BC_TWO : b.bcnt;
        w = b.word;
        if (c == BC_ONE)
            w[7:0] = 8'h00;
        if (c != BC_NONE) begin
            if (too_long || (32'(acc_bytes) + 32'(c)) > MAX_BYTES) begin
                too_long = 1'b1;
            end else begin
                acc_bytes = acc_bytes + 16'(c);
                acc_sum = ones_fold(32'(acc_sum) + 32'(w));
            end
        end
        if (!b.last)
            return;
        open_dgram = 1'b0;
        if (too_long) begin
            push_header_word('0, W_VER_LEN, 1'b1, 1'b1);
            return;
        end
        tot_len = IP_HDR_LEN + UDP_HDR_LEN + acc_bytes;
        udp_len = UDP_HDR_LEN + acc_bytes;
        w0 = {IP_VER_IHL, 8'h00, tot_len};
        w2 = {IP_TTL, IP_PROTO_UDP, 16'h0000};
        s = w0[31:16] + w0[15:0] + w2[31:16] + cfg_src_ip[31:16] + cfg_src_ip[15:0]
            + cur_dip[31:16] + cur_dip[15:0];
        w2[15:0] = ~ones_fold(s);
        // pseudo-header, UDP header and payload; a zero result stays zero
        s = cfg_src_ip[31:16] + cfg_src_ip[15:0] + cur_dip[31:16] + cur_dip[15:0]
            + IP_PROTO_UDP + udp_len + cfg_src_port + cur_dport + udp_len + acc_sum;
        udp_ck = ~ones_fold(s);
        push_header_word(w0, W_VER_LEN, 1'b0, 1'b0);
        push_header_word('0, W_ID_FRAG, 1'b0, 1'b0);
        push_header_word(w2, W_TTL_CSUM, 1'b0, 1'b0);
        push_header_word(cfg_src_ip, W_SRC_IP, 1'b0, 1'b0);
        push_header_word(cur_dip, W_DST_IP, 1'b0, 1'b0);
        push_header_word({cfg_src_port, cur_dport}, W_PORTS, 1'b0, 1'b0);
        push_header_word({udp_len, udp_ck}, W_UDP_LCSUM, 1'b1, 1'b0);
    endfunction

    // Payload driver: holds each word until its transfer, then maybe idles a burst
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || beat_taken)) begin
            beat_taken = 1'b0;
            if (tx_gap > 0) begin
                i_valid <= 1'b0;
                tx_gap = tx_gap - 1;
            end else if (word_feed_q.size() > 0) begin
                cur_beat = word_feed_q.pop_front();
                i_valid <= 1'b1;
                i_dest_ip <= cur_beat.dest_ip;
                i_dest_port <= cur_beat.dest_port;
                i_payload_word <= cur_beat.word;
                i_byte_count <= cur_beat.bcnt;
                i_last_word <= cur_beat.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side stall bursts
    always @(negedge i_clk) begin
        if (rx_gap > 0) begin
            i_stall <= 1'b1;
            rx_gap = rx_gap - 1;
        end else begin
            i_stall <= 1'b0;
            if (jitter_on && $urandom_range(0, 4) == 0)
                rx_gap = $urandom_range(1, 9);
        end
    end

    // Monitor: predict on each payload transfer, check each header transfer
    always @(posedge i_clk) begin
        t_hdr_result due;
        bit bad;
        if (i_rst_n && i_valid && !o_stall) begin
            advance_datagram(cur_beat);
            beat_taken = 1'b1;
            beats_left = beats_left - 1;
            if (jitter_on && $urandom_range(0, 3) == 0)
                tx_gap = $urandom_range(1, 9);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (hdr_due_q.size() == 0) begin
                $display("%0t: unexpected result word %h index %0d", $time,
                         o_header_word, o_word_index);
                errors = errors + 1;
            end else begin
                due = hdr_due_q.pop_front();
                bad = 1'b0;
                if (o_header_word !== due.word) begin
                    $display("%0t: header_word expected %h actual %h", $time,
                             due.word, o_header_word);
                    bad = 1'b1;
                end
                if (o_word_index !== due.idx) begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             due.idx, o_word_index);
                    bad = 1'b1;
                end
                if (o_final_word !== due.fin) begin
                    $display("%0t: final_word expected %b actual %b", $time,
                             due.fin, o_final_word);
                    bad = 1'b1;
                end
                if (o_dropped !== due.drop) begin
                    $display("%0t: dropped expected %b actual %b", $time,
                             due.drop, o_dropped);
                    bad = 1'b1;
                end
                if (bad)
                    errors = errors + 1;
            end
        end
    end

    task automatic queue_word(input logic [31:0] dip, input logic [15:0] dport,
                              input logic [15:0] w, input logic [1:0] c, input logic last);
        t_payload_beat b;
        b.dest_ip = dip;
        b.dest_port = dport;
        b.word = w;
        b.bcnt = c;
        b.last = last;
        word_feed_q.push_back(b);
        beats_left = beats_left + 1;
    endtask

    // Mostly well-formed datagrams; some words carry odd byte counts
    task automatic queue_random_datagram(output int n);
        logic [1:0]  c;
        logic [15:0] w;
        logic        last;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            last = (i == n - 1);
            c = last ? 2'($urandom_range(1, 2)) : BC_TWO;
            if ($urandom_range(0, 7) == 0)
                c = 2'($urandom_range(0, 3));
            w = 16'($urandom_range(0, 65535));
            if (c == BC_ONE && $urandom_range(0, 3) != 0)
                w[7:0] = 8'h00;
            queue_word($urandom, 16'($urandom_range(0, 65535)), w, c, last);
        end
    endtask

    // Wait for everything in flight, then let the back end go quiet
    task automatic settle();
        while (beats_left != 0 || hdr_due_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_SOURCE_IP:   cfg_src_ip = val;
            CFG_SOURCE_PORT: cfg_src_port = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial begin
        logic [15:0] balance;
        int n;
        int queued;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: all-zero datagram, mixed byte counts, empty payload
        queue_word('0, '0, 16'h0000, BC_TWO, 1'b1);
        queue_word(32'hffffffff, 16'hffff, 16'h1234, BC_TWO, 1'b0);
        queue_word(32'h12345678, 16'h0001, 16'hffff, BC_NONE, 1'b0);
        queue_word(32'h0, 16'h0, 16'habcd, BC_ONE, 1'b0);
        queue_word(32'h0, 16'h0, 16'h8001, BC_THREE, 1'b0);
        queue_word(32'h0, 16'h0, 16'hffff, BC_ONE, 1'b1);
        queue_word(32'h80000001, 16'h8000, 16'hffff, BC_NONE, 1'b1);
        settle();

        // All-ones configuration, zero UDP checksum, all-ones payload
        write_reg(CFG_SOURCE_IP, 32'hffffffff);
        write_reg(CFG_SOURCE_PORT, 32'h0000ffff);
        balance = ones_fold(cfg_src_ip[31:16] + cfg_src_ip[15:0] + 16'h0a00 + 16'h0001
                            + IP_PROTO_UDP + 16'd10 + 16'd10 + cfg_src_port + 16'd53);
        queue_word(32'h0a000001, 16'd53, ~balance, BC_TWO, 1'b1);
        queue_word(32'hffffffff, 16'hffff, 16'hffff, BC_TWO, 1'b0);
        queue_word(32'h0, 16'h0, 16'hffff, BC_TWO, 1'b0);
        queue_word(32'h0, 16'h0, 16'hffff, BC_TWO, 1'b1);
        queue_word(32'h55aa55aa, 16'haa55, 16'h00ff, BC_TWO, 1'b0);
        queue_word(32'haa55aa55, 16'h55aa, 16'hff00, BC_ONE, 1'b1);
        settle();

        // Length limit: fill to exactly the limit, go one word over, stay over
        write_reg(CFG_SOURCE_IP, $urandom);
        write_reg(CFG_SOURCE_PORT, $urandom_range(0, 65535));
        for (int i = 0; i < MAX_BYTES / 2 - 1; i++)
            queue_word($urandom, 16'd5, 16'($urandom_range(0, 65535)), BC_TWO, 1'b0);
        queue_word('0, '0, 16'h7700, BC_ONE, 1'b0);
        queue_word('0, '0, 16'h3300, BC_ONE, 1'b0);
        queue_word('0, '0, 16'h1111, BC_TWO, 1'b0);
        queue_word('0, '0, 16'h2222, BC_NONE, 1'b1);
        settle();

        // Random traffic over several settings; the last stretch runs without idling
        for (int p = 0; p < 4; p++) begin
            if (p == 3)
                jitter_on = 1'b0;
            write_reg(CFG_SOURCE_IP, $urandom);
            write_reg(CFG_SOURCE_PORT, $urandom_range(0, 65535));
            queued = 0;
            while (queued < PHASE_WORDS) begin
                queue_random_datagram(n);
                queued = queued + n;
            end
            settle();
        end

        if (errors == 0 && hdr_due_q.size() == 0)
            $display("PASS ipv4_udp_header_generator");
        else
            $display("FAIL ipv4_udp_header_generator");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAIL ipv4_udp_header_generator");
        $finish;
    end

endmodule
